FILE: rtl/core/ang_pkg.sv
// shared types and constants for the audio noise gate
package ang_pkg;

   localparam int CHAN_W = 3;
   localparam int SAMPLE_W = 24;
   localparam int ENV_W = 23;
   localparam int GAIN_W = 17;
   localparam int COEFF_W = 16;
   localparam int RAM_W = ENV_W + GAIN_W;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CHANNELS_DEFAULT = 8;

   localparam logic [ENV_W-1:0] MAG_MAX = {ENV_W{1'b1}};
   localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(65536);
   localparam logic [ENV_W-1:0] THRESHOLD_RESET = '0;
   localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(65000);

   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_COEFF = 2'd1,
      REG_BYPASS = 2'd2,
      REG_NONE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [ENV_W-1:0] threshold_level;
      logic [COEFF_W-1:0] release_coeff;
      logic bypass;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_OUT
   } state_type;

endpackage

FILE: rtl/core/ang_ram.sv
// generic single-port-write ram with registered read
module ang_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ang_csr.sv
// configuration registers behind the apb-style port
module ang_csr
   import ang_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_index_type idx;
   logic wr_en;

   assign idx = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      csr_prdata = '0;
      case (idx)
         REG_THRESHOLD: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.threshold_level);
            if (wr_en) begin
               cfg_in.threshold_level = csr_pwdata[ENV_W-1:0];
            end
         end
         REG_COEFF: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.release_coeff);
            if (wr_en) begin
               cfg_in.release_coeff = csr_pwdata[COEFF_W-1:0];
            end
         end
         REG_BYPASS: begin
            csr_prdata = CSR_DATA_W'(cfg_ff.bypass);
            if (wr_en) begin
               cfg_in.bypass = csr_pwdata[0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_level <= THRESHOLD_RESET;
         cfg_ff.release_coeff <= COEFF_RESET;
         cfg_ff.bypass <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/ang_core.sv
// sequencer and datapath: state read-modify-write and gain multiply
module ang_core
   import ang_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT,
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic [CHAN_W-1:0]   req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,
   output logic [CHAN_W-1:0]   rsp_tuser,
   output logic                ram_rd_en,
   output logic [ADDR_W-1:0]   ram_rd_addr,
   input  logic [RAM_W-1:0]    ram_rd_data,
   output logic                ram_wr_en,
   output logic [ADDR_W-1:0]   ram_wr_addr,
   output logic [RAM_W-1:0]    ram_wr_data
);

   localparam int WIDE_W = ADDR_W + CHAN_W;
   localparam int ENV_P_W = ENV_W + COEFF_W;
   localparam int GAIN_P_W = GAIN_W + COEFF_W;
   localparam int OUT_P_W = SAMPLE_W + GAIN_W + 1;

   state_type state_ff, state_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [ENV_W-1:0] mag_ff, mag_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic hit_ff, hit_in;
   logic pass_ff, pass_in;
   logic rise_ff, rise_in;
   logic [ENV_W-1:0] env_prod_ff, env_prod_in;
   logic [GAIN_W-1:0] gain_prod_ff, gain_prod_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [CHAN_W-1:0] rsp_chan_ff, rsp_chan_in;

   logic [WIDE_W-1:0] ch_wide;
   logic [ADDR_W-1:0] req_addr;
   logic in_range;
   logic [SAMPLE_W-1:0] abs_val;
   logic [ENV_W-1:0] mag;
   logic [ENV_W-1:0] env_old;
   logic [GAIN_W-1:0] gain_old;
   logic [ENV_W-1:0] diff;
   logic [ENV_P_W-1:0] env_mul;
   logic [GAIN_P_W-1:0] gain_mul;
   logic [ENV_W-1:0] env_new;
   logic [GAIN_W-1:0] gain_new;
   logic signed [OUT_P_W-1:0] out_mul;

   assign ch_wide = {{ADDR_W{1'b0}}, req_tuser};
   assign req_addr = ch_wide[ADDR_W-1:0];
   assign in_range = ch_wide < WIDE_W'(CHANNELS);

   assign abs_val = req_tdata[SAMPLE_W-1] ? (~req_tdata + SAMPLE_W'(1)) : req_tdata;
   assign mag = abs_val[SAMPLE_W-1] ? MAG_MAX : abs_val[ENV_W-1:0];

   assign env_old = hit_ff ? ram_rd_data[ENV_W-1:0] : '0;
   assign gain_old = hit_ff ? ram_rd_data[RAM_W-1:ENV_W] : UNITY;
   assign diff = env_old - mag_ff;
   assign env_mul = ENV_P_W'(cfg.release_coeff) * ENV_P_W'(diff);
   assign gain_mul = GAIN_P_W'(gain_old) * GAIN_P_W'(cfg.release_coeff);

   assign env_new = rise_ff ? mag_ff : (mag_ff + env_prod_ff);
   assign gain_new = (env_new >= cfg.threshold_level) ? UNITY : gain_prod_ff;

   assign out_mul = $signed(smp_ff) * $signed({1'b0, gain_ff});

   always_comb begin
      state_in = state_ff;
      chan_in = chan_ff;
      smp_in = smp_ff;
      mag_in = mag_ff;
      addr_in = addr_ff;
      hit_in = hit_ff;
      pass_in = pass_ff;
      rise_in = rise_ff;
      env_prod_in = env_prod_ff;
      gain_prod_in = gain_prod_ff;
      gain_in = gain_ff;
      valid_in = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_chan_in = rsp_chan_ff;
      req_tready = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      ram_wr_data = {gain_new, env_new};
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               chan_in = req_tuser;
               smp_in = req_tdata;
               mag_in = mag;
               addr_in = req_addr;
               hit_in = in_range && valid_ff[req_addr];
               pass_in = cfg.bypass || !in_range;
               gain_in = UNITY;
               ram_rd_en = 1'b1;
               state_in = (cfg.bypass || !in_range) ? ST_OUT : ST_READ;
            end
         end
         ST_READ: begin
            rise_in = mag_ff > env_old;
            env_prod_in = env_mul[ENV_P_W-1:COEFF_W];
            gain_prod_in = gain_mul[GAIN_P_W-1:COEFF_W];
            state_in = ST_CALC;
         end
         ST_CALC: begin
            ram_wr_en = 1'b1;
            valid_in[addr_ff] = 1'b1;
            gain_in = gain_new;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = out_mul[SAMPLE_W+COEFF_W-1:COEFF_W];
               rsp_chan_in = chan_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pass_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff <= pass_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      smp_ff <= smp_in;
      mag_ff <= mag_in;
      addr_ff <= addr_in;
      rise_ff <= rise_in;
      env_prod_ff <= env_prod_in;
      gain_prod_ff <= gain_prod_in;
      gain_ff <= gain_in;
      rsp_data_ff <= rsp_data_in;
      rsp_chan_ff <= rsp_chan_in;
   end

   assign ram_rd_addr = req_addr;
   assign ram_wr_addr = addr_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_chan_ff;

`ifndef SYNTHESIS
   a_read_after_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> $past(req_tvalid && req_tready))
      else $error("state read entered without an accepted beat");

   a_no_write_on_pass: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !pass_ff)
      else $error("state written for a bypassed beat");

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> gain_ff <= UNITY)
      else $error("gain above unity");

   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside output state");
`endif

endmodule

FILE: rtl/core/audio_noise_gate.sv
// audio noise gate top level
//
// req channel: one beat per sample, tdata = sample_in (signed 24 bits),
// tuser = channel. rsp channel: one beat per accepted sample, tdata =
// sample_out, tuser = channel_out, in the same order as accepted.
// csr port: threshold_level at 0x0, release_coeff at 0x4, bypass at 0x8;
// write only while the gate is idle.
// each sample passes through these steps in order: accept and state
// memory read, envelope and gain multiplies, state write-back, output
// multiply into the result register. one sample is processed at a time,
// so a new sample is accepted only once the last has left the output step;
// the rate is set by the read-modify-write of the per-channel state ram.
// bypassed or out-of-range beats skip to output and leave state untouched.
// a stalled rsp beat holds in the output register; the next sample is still
// accepted and waits in its last step until the output register frees.
// reset clears the per-channel valid bits, so every channel starts with a
// zero envelope and unity gain, and loads the register reset values.
module audio_noise_gate
   import ang_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // sample_in
   input  logic [CHAN_W-1:0]     req_tuser,   // channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // sample_out
   output logic [CHAN_W-1:0]     rsp_tuser,   // channel_out
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type cfg;
   logic ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [RAM_W-1:0] ram_rd_data;
   logic ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [RAM_W-1:0] ram_wr_data;

   ang_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ang_ram #(
      .WIDTH (RAM_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ang_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

endmodule
